// ===== rtl/ess_pkg.sv =====
// Shared types, constants and register codes for the encoder slot selector.
package ess_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int CFG_IDX_W      = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_US  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PREVIEW_TMO  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_MS   = 2'd2;

	localparam logic [31:0] DEBOUNCE_US_RST = 32'd200000;
	localparam logic [31:0] PREVIEW_TMO_RST = 32'd3500;
	localparam logic [15:0] STARTUP_MS_RST  = 16'd500;

	localparam logic [1:0] THR_NORMAL     = 2'd1;
	localparam logic [1:0] THR_AFTER_PRESS = 2'd2;

	typedef struct packed {
		logic signed [31:0] encoder_count;
		logic               button_level;
		logic               probe_active;
		logic [31:0]        now_ms;
		logic [31:0]        now_us;
	} sample_t;

	typedef struct packed {
		logic [2:0] active_slot;
		logic [2:0] preview_slot;
		logic       committed;
		logic       previewing;
	} result_t;

	typedef struct packed {
		logic [31:0] debounce_us;
		logic [31:0] preview_timeout_ms;
		logic [15:0] startup_ms;
	} cfg_t;

	// Tracking state apart from the slot numbers
	typedef struct packed {
		logic signed [31:0] reference_count;
		logic signed [31:0] latest_count;
		logic               sampled_button;
		logic               previous_button;
		logic [31:0]        press_stamp_us;
		logic [31:0]        preview_stamp_ms;
		logic               showing_flag;
		logic [1:0]         step_threshold;
	} track_t;

endpackage

// ===== rtl/ess_cfg.sv =====
// Configuration register file for the encoder slot selector.
module ess_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ess_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data,
	output ess_pkg::cfg_t                  cfg
);

	ess_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg      = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_us        <= ess_pkg::DEBOUNCE_US_RST;
			cfg_q.preview_timeout_ms <= ess_pkg::PREVIEW_TMO_RST;
			cfg_q.startup_ms         <= ess_pkg::STARTUP_MS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ess_pkg::CFG_DEBOUNCE_US: cfg_q.debounce_us        <= cfg_data;
				ess_pkg::CFG_PREVIEW_TMO: cfg_q.preview_timeout_ms <= cfg_data;
				ess_pkg::CFG_STARTUP_MS:  cfg_q.startup_ms         <= cfg_data[15:0];
				default: ; // drop writes to unknown indexes
			endcase
		end
	end

endmodule

// ===== rtl/ess_step.sv =====
// Next-state and result logic for one sample of the encoder slot selector.
module ess_step #(
	parameter int SLOT_COUNT = ess_pkg::SLOT_COUNT_DEF,
	parameter int SLOT_W     = $clog2(SLOT_COUNT)
) (
	input  ess_pkg::sample_t    sample,
	input  ess_pkg::cfg_t       cfg,
	input  logic [SLOT_W-1:0]   active_cur,
	input  logic [SLOT_W-1:0]   preview_cur,
	input  ess_pkg::track_t     track_cur,
	output logic [SLOT_W-1:0]   active_nxt,
	output logic [SLOT_W-1:0]   preview_nxt,
	output ess_pkg::track_t     track_nxt,
	output ess_pkg::result_t    result
);

	logic               resync;
	logic               press;
	logic               timeout;
	logic [SLOT_W-1:0]  active_a;
	logic [SLOT_W-1:0]  active_b;
	logic [SLOT_W-1:0]  preview_c;
	logic [SLOT_W-1:0]  preview_up;
	logic [SLOT_W-1:0]  preview_dn;
	logic signed [31:0] latest_a;
	logic signed [31:0] ref_b;
	logic               showing_b;
	logic [1:0]         thr_b;
	logic [31:0]        us_since_press;
	logic [31:0]        ms_since_move;
	logic signed [32:0] diff;
	logic [32:0]        count_gap;
	logic               step_ok;
	logic               moved;
	logic               step_dn;
	logic [SLOT_W+2:0]  active_ext;
	logic [SLOT_W+2:0]  preview_ext;

	assign us_since_press = sample.now_us - track_cur.press_stamp_us;
	assign ms_since_move  = sample.now_ms - track_cur.preview_stamp_ms;

	// Probe or startup window: adopt the preview and resync the reference
	assign resync   = sample.probe_active || (sample.now_ms < {16'd0, cfg.startup_ms});
	assign active_a = resync ? preview_cur : active_cur;
	assign latest_a = resync ? sample.encoder_count : track_cur.latest_count;

	// Debounced falling edge, judged on the previously sampled level
	assign press = !track_cur.sampled_button && track_cur.previous_button &&
		(us_since_press > cfg.debounce_us);
	assign ref_b     = press ? latest_a : (resync ? sample.encoder_count
		: track_cur.reference_count);
	assign showing_b = press ? 1'b0 : track_cur.showing_flag;
	assign thr_b     = press ? ess_pkg::THR_AFTER_PRESS : track_cur.step_threshold;
	assign active_b  = press ? preview_cur : active_a;

	// Idle preview falls back to the active slot
	assign timeout   = (ms_since_move > cfg.preview_timeout_ms) && showing_b &&
		(active_b != preview_cur);
	assign preview_c = timeout ? active_b : preview_cur;

	// Encoder movement against the reference
	assign diff      = 33'(ref_b) - 33'(sample.encoder_count);
	assign count_gap = diff[32] ? 33'(-diff) : 33'(diff);
	assign step_ok   = count_gap >= {31'd0, thr_b};
	assign moved     = step_ok && (diff != '0);
	assign step_dn   = !diff[32];

	assign preview_dn = (preview_c == '0) ? SLOT_W'(SLOT_COUNT - 1) : preview_c - 1'b1;
	assign preview_up = ({1'b0, preview_c} + 1'b1 >= (SLOT_W+1)'(SLOT_COUNT)) ? '0
		: preview_c + 1'b1;

	always_comb begin
		active_nxt  = active_b;
		preview_nxt = preview_c;
		track_nxt.reference_count  = ref_b;
		track_nxt.latest_count     = sample.encoder_count;
		track_nxt.sampled_button   = sample.button_level;
		track_nxt.previous_button  = track_cur.sampled_button;
		track_nxt.press_stamp_us   = press ? sample.now_us : track_cur.press_stamp_us;
		track_nxt.preview_stamp_ms = timeout ? sample.now_ms : track_cur.preview_stamp_ms;
		track_nxt.showing_flag     = timeout ? 1'b0 : showing_b;
		track_nxt.step_threshold   = step_ok ? ess_pkg::THR_NORMAL : thr_b;
		if (moved) begin
			preview_nxt = step_dn ? preview_dn : preview_up;
			track_nxt.reference_count  = sample.encoder_count;
			track_nxt.showing_flag     = 1'b1;
			track_nxt.preview_stamp_ms = sample.now_ms;
		end
	end

	assign active_ext  = {3'd0, active_nxt};
	assign preview_ext = {3'd0, preview_nxt};

	assign result.active_slot  = active_ext[2:0];
	assign result.preview_slot = preview_ext[2:0];
	assign result.committed    = press;
	assign result.previewing   = track_nxt.showing_flag;

endmodule

// ===== rtl/encoder_slot_selector.sv =====
// Top level of the encoder slot selector: input register, state and result register.
//
// Usage:
//   Each sample transfer on the sample channel (encoder count, button level,
//   probe flag, ms and us timestamps) yields exactly one result transfer on
//   the result channel (active slot, preview slot, committed, previewing).
//   The user must write registers (cfg channel: index, data) only while the
//   block is idle; the block does not enforce it. cfg_ready is always high
//   and unknown indexes are dropped.
// Path: a transferred sample lands in the input register; once processed,
//   its result loads the result register, which then offers the transfer.
// Throughput: one sample per cycle while result_ready is high. The update
//   is one pass of compares, a 33-bit count difference and a slot step up
//   or down between the input and result registers, so nothing iterates.
// Stall: when the receiver holds result_ready low, the result register
//   holds, the input register still fills once, and then sample_ready drops
//   until the result is taken. No result is lost or repeated.
// Reset: arst_n clears both valid flags, restores the register defaults
//   and puts the slot state in its initial form (slots 0, button released).
module encoder_slot_selector #(
	parameter int SLOT_COUNT = ess_pkg::SLOT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_ready,
	input  ess_pkg::sample_t              sample_data,
	output logic                          result_valid,
	input  logic                          result_ready,
	output ess_pkg::result_t              result_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ess_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	localparam int SLOT_W = $clog2(SLOT_COUNT);

	ess_pkg::cfg_t    cfg;
	ess_pkg::sample_t sample_s1;
	logic             valid_s1;
	ess_pkg::result_t result_s2;
	logic             valid_s2;
	logic             advance;

	logic [SLOT_W-1:0] active_q;
	logic [SLOT_W-1:0] preview_q;
	ess_pkg::track_t   track_q;
	logic [SLOT_W-1:0] active_nxt;
	logic [SLOT_W-1:0] preview_nxt;
	ess_pkg::track_t   track_nxt;
	ess_pkg::result_t  result_nxt;

	ess_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Process the held sample whenever the result register is free or draining
	assign advance      = valid_s1 && (!valid_s2 || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample_data;
		end
	end

	ess_step #(
		.SLOT_COUNT (SLOT_COUNT),
		.SLOT_W     (SLOT_W)
	) u_step (
		.sample      (sample_s1),
		.cfg         (cfg),
		.active_cur  (active_q),
		.preview_cur (preview_q),
		.track_cur   (track_q),
		.active_nxt  (active_nxt),
		.preview_nxt (preview_nxt),
		.track_nxt   (track_nxt),
		.result      (result_nxt)
	);

	// Slot state advances exactly once per processed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q                 <= '0;
			preview_q                <= '0;
			track_q.reference_count  <= '0;
			track_q.latest_count     <= '0;
			track_q.sampled_button   <= 1'b1;
			track_q.previous_button  <= 1'b0;
			track_q.press_stamp_us   <= '0;
			track_q.preview_stamp_ms <= '0;
			track_q.showing_flag     <= 1'b0;
			track_q.step_threshold   <= ess_pkg::THR_NORMAL;
		end else if (advance) begin
			active_q  <= active_nxt;
			preview_q <= preview_nxt;
			track_q   <= track_nxt;
		end
	end

	// Result register: load on advance, clear valid once the transfer is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	assign result_valid = valid_s2;
	assign result_data  = result_s2;

	a_threshold_legal: assert property (@(posedge clk) disable iff (!arst_n)
		(track_q.step_threshold == ess_pkg::THR_NORMAL) ||
		(track_q.step_threshold == ess_pkg::THR_AFTER_PRESS))
		else $error("step threshold out of range");

	a_slots_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, active_q} < (SLOT_W+1)'(SLOT_COUNT)) &&
		({1'b0, preview_q} < (SLOT_W+1)'(SLOT_COUNT)))
		else $error("slot number beyond slot count");

	a_no_overwrite_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> !sample_ready)
		else $error("input register would be overwritten");

	a_result_after_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> result_valid)
		else $error("processed sample produced no result");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(active_q) && $stable(preview_q) && $stable(track_q)))
		else $error("slot state changed without a processed sample");

endmodule

// ===== bench/tb_encoder_slot_selector.sv =====
// Self-checking testbench for the encoder slot selector: slot predictor, stimulus and checks.
`timescale 1ns / 1ps

module tb_encoder_slot_selector;

	// The package has no name for the spare index; writes to it must be dropped.
	localparam logic [ess_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

	// Cycles with no transfer on any channel before the run is declared hung.
	// The worst honest idle stretch is a long sender gap plus a long receiver
	// stall, so this leaves a wide margin.
	localparam int unsigned IDLE_LIMIT = 2000;
	// Idle padding after the last owed result so the pipeline settles.
	localparam int unsigned DRAIN_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic sample_valid = 1'b0;
	logic sample_ready;
	ess_pkg::sample_t sample_data = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	ess_pkg::result_t result_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ess_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	encoder_slot_selector uut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample_data(sample_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result_data(result_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Slot predictor: a private copy of the selector state and registers.
	// ------------------------------------------------------------------
	ess_pkg::cfg_t regs;
	ess_pkg::track_t trk;
	int unsigned slot_active;
	int unsigned slot_preview;

	// Results owed by the block, oldest first.
	ess_pkg::result_t slot_results_due[$];

	int fail_count;
	int unsigned samples_sent;
	int unsigned results_checked;
	int unsigned commits_predicted;
	int unsigned steps_predicted;
	int unsigned reverts_predicted;
	int unsigned reg_writes;

	// Work out the result for one sample and advance the predicted state.
	function automatic ess_pkg::result_t predict_slots(input ess_pkg::sample_t s);
		ess_pkg::result_t r;
		longint ref_l;
		longint last_l;
		longint span;
		logic [31:0] since_press;
		logic [31:0] since_move;
		bit stepped;

		r = '0;
		stepped = 1'b0;

		// Probing or startup window: adopt the preview and resync the counter.
		if (s.probe_active || s.now_ms < {16'd0, regs.startup_ms}) begin
			slot_active = slot_preview;
			trk.latest_count = s.encoder_count;
			trk.reference_count = s.encoder_count;
		end

		// Falling edge judged on the previous sample, gated by debounce.
		since_press = s.now_us - trk.press_stamp_us;
		if (!trk.sampled_button && trk.previous_button && since_press > regs.debounce_us) begin
			trk.reference_count = trk.latest_count;
			trk.press_stamp_us = s.now_us;
			trk.showing_flag = 1'b0;
			trk.step_threshold = ess_pkg::THR_AFTER_PRESS;
			slot_active = slot_preview;
			r.committed = 1'b1;
			commits_predicted++;
		end
		trk.previous_button = trk.sampled_button;

		// Drop a stale preview back to the active slot.
		since_move = s.now_ms - trk.preview_stamp_ms;
		if (since_move > regs.preview_timeout_ms && trk.showing_flag &&
				slot_active != slot_preview) begin
			slot_preview = slot_active;
			trk.showing_flag = 1'b0;
			trk.preview_stamp_ms = s.now_ms;
			reverts_predicted++;
		end

		// Step the preview on movement; distance taken at 64 bits.
		trk.latest_count = s.encoder_count;
		ref_l = longint'($signed(trk.reference_count));
		last_l = longint'($signed(trk.latest_count));
		span = ref_l - last_l;
		if (span < 0)
			span = -span;
		if (span >= longint'(trk.step_threshold)) begin
			trk.step_threshold = ess_pkg::THR_NORMAL;
			if (ref_l > last_l) begin
				slot_preview = (slot_preview == 0) ? ess_pkg::SLOT_COUNT_DEF - 1
					: slot_preview - 1;
				stepped = 1'b1;
			end else if (ref_l < last_l) begin
				slot_preview = (slot_preview + 1 >= ess_pkg::SLOT_COUNT_DEF) ? 0
					: slot_preview + 1;
				stepped = 1'b1;
			end
		end
		if (stepped) begin
			trk.reference_count = trk.latest_count;
			trk.showing_flag = 1'b1;
			trk.preview_stamp_ms = s.now_ms;
			steps_predicted++;
		end

		trk.sampled_button = s.button_level;

		r.active_slot = slot_active[2:0];
		r.preview_slot = slot_preview[2:0];
		r.previewing = trk.showing_flag;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checker: compare every result transfer with the oldest
	// prediction.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_results
		ess_pkg::result_t want;
		ess_pkg::result_t got;

		if (arst_n && result_valid && result_ready) begin
			got = result_data;
			if (slot_results_due.size() == 0) begin
				$error("result with no sample outstanding: %h", got);
				fail_count++;
			end else begin
				want = slot_results_due.pop_front();
				results_checked++;
				if (got.active_slot !== want.active_slot) begin
					$error("active_slot: expected %0d, got %0d", want.active_slot,
						got.active_slot);
					fail_count++;
				end
				if (got.preview_slot !== want.preview_slot) begin
					$error("preview_slot: expected %0d, got %0d", want.preview_slot,
						got.preview_slot);
					fail_count++;
				end
				if (got.committed !== want.committed) begin
					$error("committed: expected %0d, got %0d", want.committed, got.committed);
					fail_count++;
				end
				if (got.previewing !== want.previewing) begin
					$error("previewing: expected %0d, got %0d", want.previewing,
						got.previewing);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if no channel moves a transfer for too long.
	// ------------------------------------------------------------------
	int unsigned idle_cycles;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
					(cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles, %0d results still owed",
					IDLE_LIMIT, slot_results_due.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver pacing: short stalls, an occasional long one, and long runs
	// with ready held high.
	// ------------------------------------------------------------------
	initial begin : pace_result_ready
		int unsigned pick;

		wait (arst_n);
		@(negedge clk);
		forever begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end else if (pick < 38) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(10, 40)) @(negedge clk);
			end
			result_ready <= 1'b1;
			if (pick >= 90)
				repeat ($urandom_range(30, 80)) @(negedge clk);
			else
				repeat ($urandom_range(1, 4)) @(negedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	int unsigned quiet_left;

	// Mostly back-to-back, some short gaps, a few long ones, and now and
	// then a stretch with no gaps at all.
	function automatic int unsigned pick_gap();
		int unsigned pick;

		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		pick = $urandom_range(0, 99);
		if (pick < 5) begin
			quiet_left = $urandom_range(30, 80);
			return 0;
		end
		if (pick < 55)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Present one sample; entered and left at a falling edge. Valid stays
	// high into the next call when no gap is drawn.
	task automatic send_sample(input ess_pkg::sample_t s);
		int unsigned gap;

		gap = pick_gap();
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		sample_data <= s;
		do
			@(posedge clk);
		while (!sample_ready);
		slot_results_due.push_back(predict_slots(s));
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [31:0] count, input bit button, input bit probe,
			input logic [31:0] ms, input logic [31:0] us);
		ess_pkg::sample_t s;

		s.encoder_count = count;
		s.button_level = button;
		s.probe_active = probe;
		s.now_ms = ms;
		s.now_us = us;
		send_sample(s);
	endtask

	// Drop valid and hold until every owed result has arrived, then let the
	// pipeline settle so a register write lands on an idle block.
	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (slot_results_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One register transfer; valid is left high for the caller to lower.
	task automatic write_register(input logic [ess_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		unique case (idx)
			ess_pkg::CFG_DEBOUNCE_US: regs.debounce_us = data;
			ess_pkg::CFG_PREVIEW_TMO: regs.preview_timeout_ms = data;
			ess_pkg::CFG_STARTUP_MS:  regs.startup_ms = data[15:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	// Write all three registers plus the spare index. Junk rides in the upper
	// half of the startup word, which must be ignored.
	task automatic apply_settings(input logic [31:0] debounce, input logic [31:0] timeout,
			input logic [15:0] startup);
		logic [15:0] junk;

		junk = 16'($urandom_range(0, 65535));
		write_register(ess_pkg::CFG_DEBOUNCE_US, debounce);
		write_register(ess_pkg::CFG_PREVIEW_TMO, timeout);
		write_register(ess_pkg::CFG_STARTUP_MS, {junk, startup});
		write_register(CFG_IDX_UNUSED, $urandom);
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Random sample source: a plausible timeline (slow clocks, encoder
	// random walk, button toggles, short probe bursts) with some noise.
	// ------------------------------------------------------------------
	logic [31:0] tl_ms;
	logic [31:0] tl_us;
	logic signed [31:0] tl_count;
	bit tl_button;
	int unsigned probe_left;

	// Restart the timeline near zero, just short of the wrap, or anywhere.
	task automatic start_timeline();
		case ($urandom_range(0, 2))
			0: tl_ms = 32'd0;
			1: tl_ms = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			default: tl_ms = $urandom;
		endcase
		tl_us = $urandom;
		tl_count = $urandom;
		tl_button = 1'b1;
		probe_left = 0;
	endtask

	function automatic ess_pkg::sample_t next_random_sample();
		ess_pkg::sample_t s;
		int unsigned pick;
		int unsigned dt;
		int step;

		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			// Noise: every field drawn over its whole range.
			s.encoder_count = $urandom;
			s.button_level = 1'($urandom_range(0, 1));
			s.probe_active = 1'($urandom_range(0, 1));
			s.now_ms = $urandom;
			s.now_us = $urandom;
			return s;
		end

		// Advance the clocks: mostly small steps, sometimes past the
		// debounce window, occasionally past the preview timeout.
		pick = $urandom_range(0, 99);
		if (pick < 50)
			dt = $urandom_range(0, 3);
		else if (pick < 85)
			dt = $urandom_range(4, 60);
		else if (pick < 95)
			dt = $urandom_range(100, 1000);
		else
			dt = $urandom_range(2000, 6000);
		tl_ms = tl_ms + dt;
		tl_us = tl_us + dt * 1000 + $urandom_range(0, 999);

		// Move the encoder: hold, single counts, double counts, jumps.
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			step = 0;
		end else if (pick < 60) begin
			step = 1;
		end else if (pick < 85) begin
			step = -1;
		end else if (pick < 93) begin
			step = $urandom_range(0, 1) ? 2 : -2;
		end else begin
			step = int'($urandom_range(0, 1000));
			if ($urandom_range(0, 1))
				step = -step;
		end
		tl_count = tl_count + step;
		if (pick >= 97) begin
			case ($urandom_range(0, 2))
				0: tl_count = 32'sh7FFF_FFFF;
				1: tl_count = 32'sh8000_0000;
				default: tl_count = $urandom;
			endcase
		end

		if ($urandom_range(0, 99) < 25)
			tl_button = !tl_button;

		if (probe_left > 0) begin
			probe_left--;
			s.probe_active = 1'b1;
		end else if ($urandom_range(0, 99) < 3) begin
			probe_left = $urandom_range(0, 4);
			s.probe_active = 1'b1;
		end else begin
			s.probe_active = 1'b0;
		end

		s.encoder_count = tl_count;
		s.button_level = tl_button;
		s.now_ms = tl_ms;
		s.now_us = tl_us;
		return s;
	endfunction

	task automatic run_random_samples(input int unsigned n);
		start_timeline();
		repeat (n) send_sample(next_random_sample());
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Walk through each behavior once under the reset register values.
	task automatic test_directed_sequence();
		// startup window resyncs the counter
		send_fields(32'd5, 1'b1, 1'b0, 32'd0, 32'd0);
		// probe resyncs at the top of the count range
		send_fields(32'h7FFF_FFFF, 1'b1, 1'b1, 32'd1000, 32'd1000);
		// full-range jump down: one step down with wrap to the last slot
		send_fields(32'h8000_0000, 1'b1, 1'b0, 32'd1001, 32'd2000);
		// step up with wrap back to slot zero, then one more
		send_fields(32'h8000_0001, 1'b1, 1'b0, 32'd1002, 32'd3000);
		send_fields(32'h8000_0002, 1'b0, 1'b0, 32'd1003, 32'd4000);
		// press seen on the earlier level, well past debounce: commit
		send_fields(32'h8000_0002, 1'b1, 1'b0, 32'd1004, 32'd300000);
		// after a press one count is not enough, two are
		send_fields(32'h8000_0003, 1'b1, 1'b0, 32'd1005, 32'd301000);
		send_fields(32'h8000_0004, 1'b1, 1'b0, 32'd1006, 32'd302000);
		// second press inside the debounce window: ignored
		send_fields(32'h8000_0004, 1'b0, 1'b0, 32'd1007, 32'd303000);
		send_fields(32'h8000_0004, 1'b1, 1'b0, 32'd1008, 32'd350000);
		// preview timeout reverts to the active slot
		send_fields(32'h8000_0004, 1'b1, 1'b0, 32'd6000, 32'd400000);
		// move again, then let the ms clock wrap
		send_fields(32'h8000_0003, 1'b1, 1'b0, 32'd6001, 32'd401000);
		send_fields(32'h8000_0004, 1'b1, 1'b0, 32'hFFFF_FF00, 32'd402000);
		send_fields(32'h8000_0004, 1'b1, 1'b0, 32'h0000_0A00, 32'd403000);
		send_fields(32'h8000_0004, 1'b1, 1'b0, 32'h0000_1000, 32'd404000);
		// press across the us wrap
		send_fields(32'h8000_0004, 1'b0, 1'b0, 32'h0000_1001, 32'hFFFF_FFF0);
		send_fields(32'h8000_0004, 1'b1, 1'b0, 32'h0000_1002, 32'h0000_0010);
		// all-zero and all-ones count with probe released
		send_fields(32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_1003, 32'h0000_0020);
		send_fields(32'h0000_0000, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_drained();
	endtask

	// Register corners: reset values, all zero, all ones, and mixed.
	task automatic test_register_extremes();
		apply_settings(ess_pkg::DEBOUNCE_US_RST, ess_pkg::PREVIEW_TMO_RST,
			ess_pkg::STARTUP_MS_RST);
		run_random_samples(150);
		wait_drained();
		apply_settings(32'd0, 32'd0, 16'd0);
		run_random_samples(150);
		wait_drained();
		apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
		run_random_samples(150);
		wait_drained();
		apply_settings(32'd0, 32'hFFFF_FFFF, 16'd0);
		run_random_samples(150);
		wait_drained();
		apply_settings(32'hFFFF_FFFF, 32'd0, 16'hFFFF);
		run_random_samples(150);
		wait_drained();
	endtask

	// Settings drawn around the useful range of each register.
	task automatic test_random_settings();
		repeat (4) begin
			apply_settings($urandom_range(0, 500000), $urandom_range(0, 8000),
				16'($urandom_range(0, 2000)));
			run_random_samples(150);
			wait_drained();
		end
	endtask

	// Long run back on the reset values.
	task automatic test_long_soak();
		apply_settings(ess_pkg::DEBOUNCE_US_RST, ess_pkg::PREVIEW_TMO_RST,
			ess_pkg::STARTUP_MS_RST);
		run_random_samples(200);
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		// Predictor starts in the reset state of the block.
		regs.debounce_us = ess_pkg::DEBOUNCE_US_RST;
		regs.preview_timeout_ms = ess_pkg::PREVIEW_TMO_RST;
		regs.startup_ms = ess_pkg::STARTUP_MS_RST;
		trk = '0;
		trk.sampled_button = 1'b1;
		trk.step_threshold = ess_pkg::THR_NORMAL;
		slot_active = 0;
		slot_preview = 0;
		fail_count = 0;
		idle_cycles = 0;
		quiet_left = 0;

		// Hold reset, then release it on a falling edge.
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_sequence();
		test_register_extremes();
		test_random_settings();
		test_long_soak();

		if (slot_results_due.size() != 0) begin
			$error("%0d results never arrived", slot_results_due.size());
			fail_count++;
		end

		$display("Checked %0d results for %0d samples: %0d commits, %0d slot steps, %0d reverts",
			results_checked, samples_sent, commits_predicted, steps_predicted,
			reverts_predicted);
		$display("Applied %0d register writes across reset, corner and random settings",
			reg_writes);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
